// ===== hdl/asmh_pkg.sv =====
package asmh_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int SCAN_W        = $clog2(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        MODE_VSYNC       = 2'd0,
        MODE_ADAPT_SYNC  = 2'd1,
        MODE_ADAPT_ASYNC = 2'd2
    } mode_t;

    localparam logic [1:0] POLICY_AUTO   = 2'd0;
    localparam logic [1:0] POLICY_ALWAYS = 2'd1;
    localparam logic [1:0] POLICY_NEVER  = 2'd2;

    localparam logic [1:0] HINT_VSYNC = 2'd0;
    localparam logic [1:0] HINT_ASYNC = 2'd1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_EVAL   = 1'b1;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_CAPABLE = 1'b1;

    localparam logic [15:0] TO_VSYNC_RUN   = 16'd24;
    localparam logic [15:0] TO_ADAPT_RUN   = 16'd12;
    localparam logic [15:0] MIN_DWELL      = 16'd60;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [8:0]  LOCKOUT_EVENTS = 9'd300;
    localparam logic [31:0] OSC_WINDOW_MS  = 32'd2000;
    localparam logic [CNT_W-1:0] OSC_COUNT = CNT_W'(4);
    localparam logic [31:0] SPREAD_LIMIT   = 32'd500000;

    typedef struct packed {
        logic diff_en;
        logic update_en;
    } stats_ctl_t;

endpackage

// ===== hdl/asmh_cell.sv =====
module asmh_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     shift_en,
    input  logic                     valid_in,
    input  logic [31:0]              time_in,
    input  logic [31:0]              now,
    input  logic [asmh_pkg::CNT_W-1:0] cnt_in,
    output logic                     valid_out,
    output logic [31:0]              time_out,
    output logic [asmh_pkg::CNT_W-1:0] cnt_out
);
    import asmh_pkg::*;

    logic             valid_reg;
    logic [31:0]      time_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      age;
    logic             recent;

    assign age    = now - time_reg;
    assign recent = valid_reg && (age <= OSC_WINDOW_MS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            time_reg <= time_in;
        end
        cnt_reg <= cnt_in + CNT_W'(recent);
    end

    assign valid_out = valid_reg;
    assign time_out  = time_reg;
    assign cnt_out   = cnt_reg;

endmodule

// ===== hdl/asmh_stats.sv =====
module asmh_stats (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  asmh_pkg::stats_ctl_t ctl,
    input  logic [31:0]          frame_time,
    output logic [31:0]          mean,
    output logic [31:0]          spread
);
    import asmh_pkg::*;

    logic [31:0] mean_reg;
    logic [31:0] spread_reg;
    logic [31:0] diff_reg;
    logic [39:0] mean_sum;
    logic [39:0] spread_sum;

    // x*224 + y*32, then >> 8
    assign mean_sum   = {mean_reg, 8'd0} - {3'd0, mean_reg, 5'd0} + {3'd0, frame_time, 5'd0};
    assign spread_sum = {spread_reg, 8'd0} - {3'd0, spread_reg, 5'd0} + {3'd0, diff_reg, 5'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg   <= '0;
            spread_reg <= '0;
        end else if (ctl.update_en) begin
            mean_reg   <= mean_sum[39:8];
            spread_reg <= spread_sum[39:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.diff_en) begin
            diff_reg <= (frame_time >= mean_reg) ? (frame_time - mean_reg)
                                                 : (mean_reg - frame_time);
        end
    end

    assign mean   = mean_reg;
    assign spread = spread_reg;

endmodule

// ===== hdl/adaptive_sync_mode_hysteresis_unit.sv =====
// Frame-time sample: accepted, then the diff, update and commit states; commit loads the
// output register. Evaluation event: evaluate then commit; when a confirmed switch walks
// the switch-time cell row, the scan state lies between them
// (the count passes one cell per cycle); one request at a time.
// Input is taken while an earlier result waits in the output register (commit stalls).
// aresetn is synchronous, active low: mode vsync, counters, statistics, history
// valid bits and registers cleared.
module adaptive_sync_mode_hysteresis_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] frame_time_ns, [63:32] time_ms, [64] hint_valid, [65] on_output,
    // [66] full_screen, [68:67] hint, [71:69] zero
    input  logic [71:0] s_tdata,
    // [0] action
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] mode, [2] switched, [3] locked_out, [35:4] frame_time_mean,
    // [67:36] frame_time_spread, [68] stable, [71:69] zero
    output logic [71:0] m_tdata
);
    import asmh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMP_DIFF,
        ST_SAMP_UPD,
        ST_EVAL,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  policy_reg, policy_next;
    logic        capable_reg, capable_next;
    logic        act_reg, act_next;
    logic [31:0] ft_reg, ft_next;
    logic [31:0] now_reg, now_next;
    logic        hv_reg, hv_next;
    logic        on_reg, on_next;
    logic        full_reg, full_next;
    logic [1:0]  hint_reg, hint_next;
    mode_t       cur_reg, cur_next;
    mode_t       pend_mode_reg, pend_mode_next;
    logic [15:0] pend_cnt_reg, pend_cnt_next;
    logic [15:0] dwell_reg, dwell_next;
    logic [8:0]  cool_reg, cool_next;
    logic        lock_reg, lock_next;
    mode_t       target_reg, target_next;
    logic        sw_reg, sw_next;
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;

    stats_ctl_t  stats_ctl;
    logic [31:0] mean;
    logic [31:0] spread;
    logic        stable;
    mode_t       tgt;
    logic [15:0] dwell_inc;
    logic [15:0] pc_val;
    logic [15:0] run;
    logic        shift_en;
    logic        cfg_wr;

    logic                 valid_chain [0:HISTORY_DEPTH];
    logic [31:0]          time_chain  [0:HISTORY_DEPTH];
    logic [CNT_W-1:0]     cnt_chain   [0:HISTORY_DEPTH];

    asmh_stats u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (stats_ctl),
        .frame_time (ft_reg),
        .mean       (mean),
        .spread     (spread)
    );

    // newest switch time enters at cell 0
    assign valid_chain[0] = 1'b1;
    assign time_chain[0]  = now_reg;
    assign cnt_chain[0]   = '0;

    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        asmh_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .valid_in  (valid_chain[k]),
            .time_in   (time_chain[k]),
            .now       (now_reg),
            .cnt_in    (cnt_chain[k]),
            .valid_out (valid_chain[k+1]),
            .time_out  (time_chain[k+1]),
            .cnt_out   (cnt_chain[k+1])
        );
    end

    assign stable = spread < SPREAD_LIMIT;

    always_comb begin
        priority if (!capable_reg || policy_reg == POLICY_NEVER) begin
            tgt = MODE_VSYNC;
        end else if (!hv_reg || !on_reg) begin
            tgt = MODE_VSYNC;
        end else if (policy_reg == POLICY_ALWAYS) begin
            if (hint_reg == HINT_ASYNC) begin
                tgt = MODE_ADAPT_ASYNC;
            end else if (hint_reg != HINT_VSYNC) begin
                tgt = MODE_ADAPT_SYNC;
            end else begin
                tgt = MODE_VSYNC;
            end
        end else if (!full_reg || hint_reg == HINT_VSYNC) begin
            tgt = MODE_VSYNC;
        end else if (stable && cur_reg == MODE_VSYNC) begin
            tgt = MODE_VSYNC;
        end else begin
            tgt = (hint_reg == HINT_ASYNC) ? MODE_ADAPT_ASYNC : MODE_ADAPT_SYNC;
        end
    end

    assign dwell_inc = (dwell_reg != COUNT_MAX) ? dwell_reg + 16'd1 : dwell_reg;
    assign pc_val    = (tgt == pend_mode_reg)
                     ? ((pend_cnt_reg != COUNT_MAX) ? pend_cnt_reg + 16'd1 : pend_cnt_reg)
                     : 16'd1;
    assign run       = (tgt == MODE_VSYNC) ? TO_VSYNC_RUN : TO_ADAPT_RUN;

    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        state_next     = state_reg;
        policy_next    = policy_reg;
        capable_next   = capable_reg;
        act_next       = act_reg;
        ft_next        = ft_reg;
        now_next       = now_reg;
        hv_next        = hv_reg;
        on_next        = on_reg;
        full_next      = full_reg;
        hint_next      = hint_reg;
        cur_next       = cur_reg;
        pend_mode_next = pend_mode_reg;
        pend_cnt_next  = pend_cnt_reg;
        dwell_next     = dwell_reg;
        cool_next      = cool_reg;
        lock_next      = lock_reg;
        target_next    = target_reg;
        sw_next        = sw_reg;
        scan_cnt_next  = scan_cnt_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        stats_ctl      = '0;
        shift_en       = 1'b0;

        if (cfg_wr) begin
            unique case (paddr[2])
                REG_POLICY:  policy_next  = pwdata[1:0];
                REG_CAPABLE: capable_next = pwdata[0];
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser[0];
                    ft_next    = s_tdata[31:0];
                    now_next   = s_tdata[63:32];
                    hv_next    = s_tdata[64];
                    on_next    = s_tdata[65];
                    full_next  = s_tdata[66];
                    hint_next  = s_tdata[68:67];
                    sw_next    = 1'b0;
                    state_next = (s_tuser[0] == ACT_EVAL) ? ST_EVAL : ST_SAMP_DIFF;
                end
            end
            ST_SAMP_DIFF: begin
                stats_ctl.diff_en = 1'b1;
                state_next        = ST_SAMP_UPD;
            end
            ST_SAMP_UPD: begin
                stats_ctl.update_en = 1'b1;
                state_next          = ST_COMMIT;
            end
            ST_EVAL: begin
                target_next = tgt;
                state_next  = ST_COMMIT;
                dwell_next  = dwell_inc;
                priority if (tgt == cur_reg) begin
                    pend_cnt_next  = '0;
                    pend_mode_next = cur_reg;
                end else if (dwell_reg < MIN_DWELL) begin
                    dwell_next = dwell_inc;
                end else if (cool_reg != '0) begin
                    cool_next = cool_reg - 9'd1;
                    if (cool_reg == 9'd1) begin
                        lock_next = 1'b0;
                    end
                end else if (lock_reg) begin
                    dwell_next = dwell_inc;
                end else begin
                    pend_mode_next = tgt;
                    pend_cnt_next  = pc_val;
                    if (pc_val >= run) begin
                        dwell_next    = dwell_reg;
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg == SCAN_W'(HISTORY_DEPTH - 1)) begin
                    state_next = ST_COMMIT;
                    if (cnt_chain[HISTORY_DEPTH] >= OSC_COUNT) begin
                        lock_next      = 1'b1;
                        cool_next      = LOCKOUT_EVENTS;
                        cur_next       = MODE_VSYNC;
                        pend_mode_next = MODE_VSYNC;
                        pend_cnt_next  = '0;
                        sw_next        = (cur_reg != MODE_VSYNC);
                        dwell_next     = dwell_inc;
                    end else begin
                        pend_cnt_next = '0;
                        cur_next      = target_reg;
                        sw_next       = 1'b1;
                        dwell_next    = 16'd1;
                        shift_en      = 1'b1;
                    end
                end else begin
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
            end
            ST_COMMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, stable, spread, mean, lock_reg, sw_reg, cur_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            policy_reg    <= POLICY_AUTO;
            capable_reg   <= 1'b0;
            cur_reg       <= MODE_VSYNC;
            pend_mode_reg <= MODE_VSYNC;
            pend_cnt_reg  <= '0;
            dwell_reg     <= '0;
            cool_reg      <= '0;
            lock_reg      <= 1'b0;
            sw_reg        <= 1'b0;
            scan_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            capable_reg   <= capable_next;
            cur_reg       <= cur_next;
            pend_mode_reg <= pend_mode_next;
            pend_cnt_reg  <= pend_cnt_next;
            dwell_reg     <= dwell_next;
            cool_reg      <= cool_next;
            lock_reg      <= lock_next;
            sw_reg        <= sw_next;
            scan_cnt_reg  <= scan_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        act_reg     <= act_next;
        ft_reg      <= ft_next;
        now_reg     <= now_next;
        hv_reg      <= hv_next;
        on_reg      <= on_next;
        full_reg    <= full_next;
        hint_reg    <= hint_next;
        target_reg  <= target_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CAPABLE) ? {31'd0, capable_reg} : {30'd0, policy_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_cool_implies_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        (cool_reg != '0) |-> lock_reg)
        else $error("cooldown running without lockout");

    a_scan_needs_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (target_reg != cur_reg) && (act_reg == ACT_EVAL))
        else $error("history walk without a pending mode change");

    a_lock_forces_vsync: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(lock_reg) |-> (cur_reg == MODE_VSYNC))
        else $error("lockout entered outside vsync");

    a_adaptive_switch_unlocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2] && (m_tdata[1:0] != MODE_VSYNC)) |-> !m_tdata[3])
        else $error("switch to adaptive mode reported under lockout");

endmodule

// ===== test/mode_hysteresis_checker.sv =====
module mode_hysteresis_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          errors,
    output int          outstanding,
    output int          n_results,
    output int          n_switches,
    output int          n_trips
);
    import asmh_pkg::*;

    typedef struct packed {
        mode_t       mode;
        logic        switched;
        logic        locked;
        logic [31:0] mean;
        logic [31:0] spread;
        logic        stable;
    } status_t;

    logic [1:0]        policy;
    logic              capable;
    mode_t             cur_mode;
    mode_t             pend_mode;
    logic [15:0]       pend_cnt;
    logic [15:0]       dwell;
    logic [8:0]        cooldown;
    logic              locked;
    logic [31:0]       switch_ms [HISTORY_DEPTH];
    logic [SCAN_W-1:0] head;
    logic [CNT_W-1:0]  fill;
    logic [31:0]       mean;
    logic [31:0]       spread;
    status_t           expected_status [$];

    function automatic void fold_sample(input logic [31:0] ft);
        logic [63:0] dev;
        logic [63:0] m_next;
        logic [63:0] s_next;
        dev = (ft >= mean) ? 64'(ft - mean) : 64'(mean - ft);
        // new value weighted 32/256, history 224/256
        m_next = (64'(mean) * 64'd224 + 64'(ft) * 64'd32) >> 8;
        s_next = (64'(spread) * 64'd224 + dev * 64'd32) >> 8;
        mean   = m_next[31:0];
        spread = s_next[31:0];
    endfunction

    function automatic mode_t target_mode(input logic vld, input logic onout,
                                          input logic full, input logic [1:0] hint);
        if (!capable || policy == POLICY_NEVER || !vld || !onout)
            return MODE_VSYNC;
        if (policy == POLICY_ALWAYS) begin
            if (hint == HINT_ASYNC)
                return MODE_ADAPT_ASYNC;
            if (hint != HINT_VSYNC)
                return MODE_ADAPT_SYNC;
            return MODE_VSYNC;
        end
        if (!full || hint == HINT_VSYNC)
            return MODE_VSYNC;
        if (spread < SPREAD_LIMIT && cur_mode == MODE_VSYNC)
            return MODE_VSYNC;
        return (hint == HINT_ASYNC) ? MODE_ADAPT_ASYNC : MODE_ADAPT_SYNC;
    endfunction

    function automatic logic too_many_recent(input logic [31:0] now);
        int                recent;
        logic [SCAN_W-1:0] idx;
        recent = 0;
        if (fill < OSC_COUNT)
            return 1'b0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (i < fill) begin
                idx = SCAN_W'(head - 1 - i);
                if (32'(now - switch_ms[idx]) <= OSC_WINDOW_MS)
                    recent++;
            end
        end
        return recent >= OSC_COUNT;
    endfunction

    function automatic logic grant_switch(input mode_t tgt, input logic [31:0] now);
        logic [15:0] need;
        if (tgt == cur_mode) begin
            pend_cnt  = '0;
            pend_mode = cur_mode;
            return 1'b0;
        end
        if (dwell < MIN_DWELL)
            return 1'b0;
        if (cooldown != 0) begin
            cooldown--;
            if (cooldown == 0)
                locked = 1'b0;
            return 1'b0;
        end
        if (locked)
            return 1'b0;
        if (tgt == pend_mode) begin
            if (pend_cnt != COUNT_MAX)
                pend_cnt++;
        end else begin
            pend_mode = tgt;
            pend_cnt  = 16'd1;
        end
        need = (tgt == MODE_VSYNC) ? TO_VSYNC_RUN : TO_ADAPT_RUN;
        if (pend_cnt < need)
            return 1'b0;
        if (too_many_recent(now)) begin
            // forced vsync: no history entry, dwell kept
            locked    = 1'b1;
            cooldown  = LOCKOUT_EVENTS;
            cur_mode  = MODE_VSYNC;
            pend_mode = MODE_VSYNC;
            pend_cnt  = '0;
            n_trips++;
            return 1'b0;
        end
        pend_cnt = '0;
        return 1'b1;
    endfunction

    function automatic void predict_request(input logic act, input logic [71:0] data);
        mode_t       was;
        mode_t       tgt;
        logic [31:0] now;
        status_t     e;
        was = cur_mode;
        now = data[63:32];
        if (act == ACT_SAMPLE) begin
            fold_sample(data[31:0]);
        end else begin
            tgt = target_mode(data[64], data[65], data[66], data[68:67]);
            if (grant_switch(tgt, now)) begin
                cur_mode        = tgt;
                dwell           = '0;
                switch_ms[head] = now;
                head++;
                if (fill < HISTORY_DEPTH)
                    fill++;
                n_switches++;
            end
            if (dwell != COUNT_MAX)
                dwell++;
        end
        e.mode     = cur_mode;
        e.switched = (cur_mode != was);
        e.locked   = locked;
        e.mean     = mean;
        e.spread   = spread;
        e.stable   = (spread < SPREAD_LIMIT);
        expected_status.push_back(e);
    endfunction

    initial begin
        errors      = 0;
        outstanding = 0;
        n_results   = 0;
        n_switches  = 0;
        n_trips     = 0;
    end

    always @(posedge aclk) begin : watch
        status_t got;
        status_t want;
        if (!aresetn) begin
            policy    = POLICY_AUTO;
            capable   = 1'b0;
            cur_mode  = MODE_VSYNC;
            pend_mode = MODE_VSYNC;
            pend_cnt  = '0;
            dwell     = '0;
            cooldown  = '0;
            locked    = 1'b0;
            head      = '0;
            fill      = '0;
            mean      = '0;
            spread    = '0;
            expected_status.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_POLICY)
                    policy = pwdata[1:0];
                else
                    capable = pwdata[0];
            end
            if (m_tvalid && m_tready) begin
                n_results++;
                got.mode     = mode_t'(m_tdata[1:0]);
                got.switched = m_tdata[2];
                got.locked   = m_tdata[3];
                got.mean     = m_tdata[35:4];
                got.spread   = m_tdata[67:36];
                got.stable   = m_tdata[68];
                if (expected_status.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d with no request pending: %h", n_results, m_tdata);
                end else begin
                    want = expected_status.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("result %0d mismatch", n_results);
                            $display("  exp mode %0d sw %0d lock %0d mean %0d spread %0d st %0d",
                                     want.mode, want.switched, want.locked, want.mean,
                                     want.spread, want.stable);
                            $display("  got mode %0d sw %0d lock %0d mean %0d spread %0d st %0d",
                                     got.mode, got.switched, got.locked, got.mean,
                                     got.spread, got.stable);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser[0], s_tdata);
        end
        outstanding = expected_status.size();
    end

endmodule

// ===== test/tb.sv =====
module tb;
    import asmh_pkg::*;

    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         HOLD_CYCLES  = 150;
    localparam int         PHASE_ITEMS  = 140;
    localparam logic [1:0] POLICY_SPARE = 2'd3;

    localparam logic [1:0] PHASE_POLICY [8] = '{POLICY_ALWAYS, POLICY_AUTO, POLICY_SPARE,
                                               POLICY_ALWAYS, POLICY_NEVER, POLICY_AUTO,
                                               POLICY_ALWAYS, POLICY_AUTO};
    localparam logic       PHASE_CAP [8]    = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam int         SRC_IDLE [4]     = '{0, 81, 0, 38};
    localparam int         SINK_STALL [4]   = '{0, 0, 81, 38};

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    int          errors;
    int          outstanding;
    int          n_results;
    int          n_switches;
    int          n_trips;
    int          n_samples;
    int          n_evals;
    int          src_idle;
    int          sink_stall;
    int          hold_seq;
    logic [31:0] now_ms;

    adaptive_sync_mode_hysteresis_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mode_hysteresis_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding),
        .n_results   (n_results),
        .n_switches  (n_switches),
        .n_trips     (n_trips)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // tdata: [31:0] frame_time_ns, [63:32] time_ms, [64] hint_valid, [65] on_output,
    // [66] full_screen, [68:67] hint
    function automatic logic [71:0] pack_request(input logic [31:0] ft, input logic [31:0] tms,
                                                 input logic vld, input logic onout,
                                                 input logic full, input logic [1:0] hint);
        return {3'b000, hint, full, onout, vld, tms, ft};
    endfunction

    // entered and left at a falling edge
    task automatic push_request(input logic act, input logic [71:0] data);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (act == ACT_SAMPLE)
            n_samples++;
        else
            n_evals++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (HISTORY_DEPTH + 8) @(negedge aclk);
    endtask

    task automatic eval_run(input int n, input logic [31:0] step, input logic vld,
                            input logic onout, input logic full, input logic [1:0] hint);
        repeat (n) begin
            now_ms += step;
            push_request(ACT_EVAL, pack_request($urandom, now_ms, vld, onout, full, hint));
        end
    endtask

    task automatic run_phase(input int budget);
        int          sent;
        int          n;
        int          kind;
        logic [31:0] base;
        logic [31:0] jit;
        logic [31:0] step;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(11);
            if (kind <= 2) begin
                n = $urandom_range(40, 8);
                case ($urandom_range(3))
                    0:       base = 32'd16666667;
                    1:       base = 32'd8333333;
                    2:       base = 32'd33333333;
                    default: base = $urandom;
                endcase
                jit = $urandom_range(1) ? $urandom_range(60000) : $urandom_range(4000000);
                repeat (n)
                    push_request(ACT_SAMPLE, pack_request(base - jit + $urandom_range(2 * jit),
                                 $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                                 2'($urandom)));
                sent += n;
            end else if (kind <= 7) begin
                n    = $urandom_range(100, 1);
                step = ($urandom_range(9) == 0) ? $urandom_range(3000) : $urandom_range(6, 1);
                eval_run(n, step, $urandom_range(15) != 0, $urandom_range(15) != 0,
                         $urandom_range(7) != 0, 2'($urandom_range(3)));
                sent += n;
            end else if (kind == 8) begin
                n = $urandom_range(4, 1);
                repeat (n)
                    push_request(1'($urandom_range(1)), pack_request($urandom, $urandom,
                                 1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom)));
                sent += n;
            end else if (kind == 9) begin
                now_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(3000);
            end else if (kind == 10) begin
                // runs just past dwell plus confirmation, alternating targets
                for (int r = 0; r < 4; r++) begin
                    eval_run(74, $urandom_range(4, 1), 1'b1, 1'b1, 1'b1,
                             (r % 2) ? HINT_VSYNC : HINT_ASYNC);
                end
                sent += 296;
            end else begin
                n = $urandom_range(90, 20);
                eval_run(n, $urandom_range(8, 1), 1'b1, 1'b1, 1'b1, 2'($urandom_range(3, 2)));
                sent += n;
            end
        end
    endtask

    initial begin : sink
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (seen != hold_seq) begin
                seen      = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_SAMPLE;
        src_idle   = 0;
        sink_stall = 0;
        hold_seq   = 0;
        n_samples  = 0;
        n_evals    = 0;
        now_ms     = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(REG_POLICY, {30'($urandom), POLICY_ALWAYS});
        write_reg(REG_CAPABLE, 32'h0000_0001);

        push_request(ACT_SAMPLE, pack_request(32'h0, 32'h0, 1'b0, 1'b0, 1'b0, HINT_VSYNC));
        push_request(ACT_SAMPLE, pack_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                                              2'd3));
        push_request(ACT_SAMPLE, pack_request(32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0,
                                              HINT_VSYNC));
        push_request(ACT_SAMPLE, pack_request(32'h0, 32'h0, 1'b0, 1'b0, 1'b0, HINT_VSYNC));
        push_request(ACT_SAMPLE, pack_request(32'd16666667, 32'h0, 1'b0, 1'b0, 1'b0,
                                              HINT_VSYNC));
        push_request(ACT_EVAL, pack_request(32'h0, 32'h0, 1'b1, 1'b1, 1'b1, HINT_VSYNC));
        push_request(ACT_EVAL, pack_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                                            HINT_ASYNC));
        push_request(ACT_EVAL, pack_request(32'h0, 32'd5, 1'b1, 1'b1, 1'b1, 2'd2));
        push_request(ACT_EVAL, pack_request(32'h0, 32'd10, 1'b1, 1'b1, 1'b1, 2'd3));
        push_request(ACT_EVAL, pack_request(32'h0, 32'd15, 1'b0, 1'b1, 1'b1, HINT_ASYNC));
        push_request(ACT_EVAL, pack_request(32'h0, 32'd20, 1'b1, 1'b0, 1'b1, HINT_ASYNC));
        push_request(ACT_EVAL, pack_request(32'h0, 32'd25, 1'b1, 1'b1, 1'b0, HINT_ASYNC));
        push_request(ACT_EVAL, pack_request(32'h0, 32'd30, 1'b0, 1'b0, 1'b0, 2'd3));
        now_ms = 32'd30;
        drain();

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_POLICY, {30'($urandom), PHASE_POLICY[p]});
            write_reg(REG_CAPABLE, {31'($urandom), PHASE_CAP[p]});
            src_idle   = SRC_IDLE[p % 4];
            sink_stall = SINK_STALL[p % 4];
            if (p == 0)
                hold_seq++;
            run_phase(PHASE_ITEMS);
            drain();
        end

        $display("%0d requests (%0d samples, %0d evaluations), %0d results checked",
                 n_samples + n_evals, n_samples, n_evals, n_results);
        $display("8 register settings, %0d mode switches, %0d oscillation lockouts",
                 n_switches, n_trips);
        if (errors == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== adaptive_sync_mode_hysteresis_unit.f =====
hdl/asmh_pkg.sv
hdl/asmh_cell.sv
hdl/asmh_stats.sv
hdl/adaptive_sync_mode_hysteresis_unit.sv
test/mode_hysteresis_checker.sv
test/tb.sv
